@@ rtl/core/pfbfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfbfe_pkg
// Shared types and fixed field widths for the filter bank front end.
// ----------------------------------------------------------------------------
package pfbfe_pkg;

	localparam int SAMP_W = 8;   // recorder sample part
	localparam int COEF_W = 16;  // Q1.15 coefficient
	localparam int HIST_W = 16;  // packed history word: filter real high, imag low
	localparam int PROD_W = 24;  // 8 x 16 signed product
	localparam int SUM_W  = 32;  // weighted sum
	localparam int BIN_W  = 8;   // bin index port
	localparam int CIDX_W = 10;  // coefficient slot port

	localparam logic FUNC_COEFF = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	// read pipeline control handed to the MAC
	typedef struct packed {
		logic clear;     // start of a new sum
		logic valid_s1;  // RAM read data valid this cycle
		logic last_s1;   // read data belongs to the newest tap
	} mac_ctrl_t;

endpackage

@@ rtl/core/pfbfe_ram.sv @@
// ----------------------------------------------------------------------------
// pfbfe_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfbfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/pfbfe_mac.sv @@
// ----------------------------------------------------------------------------
// pfbfe_mac
// Complex-by-real multiply stage and 32-bit accumulator, one tap per cycle.
// ----------------------------------------------------------------------------
module pfbfe_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pfbfe_pkg::mac_ctrl_t                ctrl,
	input  logic [pfbfe_pkg::HIST_W-1:0]        hist_data,
	input  logic [pfbfe_pkg::COEF_W-1:0]        coef_data,
	output logic                                done,
	output logic signed [pfbfe_pkg::SUM_W-1:0]  sum_re,
	output logic signed [pfbfe_pkg::SUM_W-1:0]  sum_im
);

	logic signed [pfbfe_pkg::SAMP_W-1:0] h_re;
	logic signed [pfbfe_pkg::SAMP_W-1:0] h_im;
	logic signed [pfbfe_pkg::COEF_W-1:0] coef;
	logic signed [pfbfe_pkg::PROD_W-1:0] prod_re_s2;
	logic signed [pfbfe_pkg::PROD_W-1:0] prod_im_s2;
	logic                                valid_s2;
	logic                                last_s2;
	logic signed [pfbfe_pkg::SUM_W-1:0]  acc_re_q;
	logic signed [pfbfe_pkg::SUM_W-1:0]  acc_im_q;

	assign h_re = $signed(hist_data[pfbfe_pkg::HIST_W-1:pfbfe_pkg::SAMP_W]);
	assign h_im = $signed(hist_data[pfbfe_pkg::SAMP_W-1:0]);
	assign coef = $signed(coef_data);

	// product register
	always_ff @(posedge clk) begin
		prod_re_s2 <= pfbfe_pkg::PROD_W'(h_re) * pfbfe_pkg::PROD_W'(coef);
		prod_im_s2 <= pfbfe_pkg::PROD_W'(h_im) * pfbfe_pkg::PROD_W'(coef);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s2 <= ctrl.valid_s1;
			last_s2  <= ctrl.valid_s1 & ctrl.last_s1;
		end
	end

	// sums cannot overflow: up to 256 taps of 24-bit products fit in 32 bits
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (valid_s2) begin
			acc_re_q <= acc_re_q + pfbfe_pkg::SUM_W'(prod_re_s2);
			acc_im_q <= acc_im_q + pfbfe_pkg::SUM_W'(prod_im_s2);
		end
	end

	assign done   = valid_s2 & last_s2;
	assign sum_re = acc_re_q;
	assign sum_im = acc_im_q;

endmodule

@@ rtl/core/polyphase_filter_bank_front_end_unit.sv @@
// ----------------------------------------------------------------------------
// polyphase_filter_bank_front_end_unit
// Weighting front end of a polyphase filter bank: sample history, coefficient
// table and a tap-serial multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage: each input transaction is either a coefficient write (func=1) or a
// recorder sample (func=0). Samples enter with real and imaginary swapped and
// are stored in a circular history of NTAPS blocks of BLOCK_LEN samples. Once
// NTAPS-1 whole blocks have gone by, every sample at block position k produces
// one output transaction carrying bin k, the exact 32-bit sum over the taps of
// history times coefficient (tap 0 = oldest block, last tap = current block).
// Timing: a coefficient write and a sample that produces no bin are taken
// without raising in_stall. A sample that produces a bin raises in_stall
// until it is done: the taps are read one per cycle through the single
// read port of each memory, then a product stage, an accumulate and a handoff
// to the output register. The output register lets the next transaction be
// accepted while a bin still waits on out_stall; only a second finished bin
// waits for the first to leave. Coefficient slots not written since reset must
// not be used by any bin; writes to slots at or beyond NTAPS*BLOCK_LEN are
// dropped. Memories need no clearing after reset.
// ----------------------------------------------------------------------------
module polyphase_filter_bank_front_end_unit #(
	parameter int NTAPS     = 4,
	parameter int BLOCK_LEN = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   func,
	input  logic signed [pfbfe_pkg::SAMP_W-1:0]    rec_real,
	input  logic signed [pfbfe_pkg::SAMP_W-1:0]    rec_imag,
	input  logic [pfbfe_pkg::CIDX_W-1:0]           coeff_index,
	input  logic signed [pfbfe_pkg::COEF_W-1:0]    coeff_value,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [pfbfe_pkg::BIN_W-1:0]            bin_index,
	output logic signed [pfbfe_pkg::SUM_W-1:0]     out_real,
	output logic signed [pfbfe_pkg::SUM_W-1:0]     out_imag,
	output logic                                   frame_last
);

	localparam int HIST_DEPTH = NTAPS * BLOCK_LEN;
	localparam int AW = $clog2(HIST_DEPTH);   // history / coefficient address
	localparam int KW = $clog2(BLOCK_LEN);    // position within block
	localparam int TW = $clog2(NTAPS);        // tap counter
	localparam int FW = $clog2(NTAPS + 1);    // filled-block count, saturates at NTAPS

	// ---------------------------------------------------------------- state
	pfbfe_pkg::state_t state_q;
	pfbfe_pkg::state_t state_nxt;

	logic [AW-1:0] pos_q;        // next history slot
	logic [KW-1:0] k_q;          // position of pos_q within its block
	logic [FW-1:0] filled_q;     // completed blocks
	logic [TW-1:0] tap_q;        // tap being read
	logic [AW-1:0] hist_addr_q;  // history read address of tap_q
	logic [AW-1:0] coef_addr_q;  // coefficient read address of tap_q
	logic [KW-1:0] item_k_q;     // bin of the sum in progress
	logic          rd_valid_s1;
	logic          rd_last_s1;

	// output register
	logic                               out_valid_q;
	logic [pfbfe_pkg::BIN_W-1:0]        bin_q;
	logic signed [pfbfe_pkg::SUM_W-1:0] out_real_q;
	logic signed [pfbfe_pkg::SUM_W-1:0] out_imag_q;
	logic                               frame_last_q;

	// ---------------------------------------------------------------- decode
	logic in_acc;
	logic acc_coeff;
	logic acc_data;
	logic primed;
	logic start_sum;
	logic coeff_in_range;
	logic issue;
	logic issue_last;
	logic out_take;
	logic out_load;

	// memory ports
	logic                         hist_we;
	logic [pfbfe_pkg::HIST_W-1:0] hist_wdata;
	logic [pfbfe_pkg::HIST_W-1:0] hist_rdata;
	logic                         coef_we;
	logic [AW-1:0]                coef_waddr;
	logic [pfbfe_pkg::COEF_W-1:0] coef_rdata;

	// MAC
	pfbfe_pkg::mac_ctrl_t               mac_ctrl;
	logic                               mac_done;
	logic signed [pfbfe_pkg::SUM_W-1:0] mac_re;
	logic signed [pfbfe_pkg::SUM_W-1:0] mac_im;

	// address one block further on, wrapping around the history
	function automatic logic [AW-1:0] next_block(input logic [AW-1:0] a);
		logic [AW:0] s;
		s = {1'b0, a} + (AW+1)'(BLOCK_LEN);
		if (s >= (AW+1)'(HIST_DEPTH)) begin
			s = s - (AW+1)'(HIST_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign in_acc    = in_valid & ~in_stall;
	assign acc_coeff = in_acc & (func == pfbfe_pkg::FUNC_COEFF);
	assign acc_data  = in_acc & (func != pfbfe_pkg::FUNC_COEFF);
	assign primed    = (filled_q >= FW'(NTAPS - 1));
	assign start_sum = acc_data & primed;

	assign coeff_in_range = ({22'd0, coeff_index} < 32'(HIST_DEPTH));

	assign out_take = out_valid_q & ~out_stall;

	// ---------------------------------------------------------------- FSM
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pfbfe_pkg::ST_IDLE: begin
				if (start_sum) begin
					state_nxt = pfbfe_pkg::ST_ISSUE;
				end
			end
			pfbfe_pkg::ST_ISSUE: begin
				if (tap_q == TW'(NTAPS - 1)) begin
					state_nxt = pfbfe_pkg::ST_DRAIN;
				end
			end
			pfbfe_pkg::ST_DRAIN: begin
				if (mac_done) begin
					state_nxt = pfbfe_pkg::ST_HOLD;
				end
			end
			pfbfe_pkg::ST_HOLD: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = pfbfe_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pfbfe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		issue      = 1'b0;
		issue_last = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			pfbfe_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			pfbfe_pkg::ST_ISSUE: begin
				issue      = 1'b1;
				issue_last = (tap_q == TW'(NTAPS - 1));
			end
			pfbfe_pkg::ST_DRAIN: begin
			end
			pfbfe_pkg::ST_HOLD: begin
				out_load = ~out_valid_q | ~out_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfbfe_pkg::ST_IDLE;
			pos_q       <= '0;
			k_q         <= '0;
			filled_q    <= '0;
			tap_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rd_valid_s1 <= issue;
			rd_last_s1  <= issue_last;

			// write pointer advances on every sample, primed or not
			if (acc_data) begin
				pos_q <= (pos_q == AW'(HIST_DEPTH - 1)) ? '0 : pos_q + 1'b1;
				k_q   <= (k_q == KW'(BLOCK_LEN - 1)) ? '0 : k_q + 1'b1;
				if (k_q == KW'(BLOCK_LEN - 1) && filled_q < FW'(NTAPS)) begin
					filled_q <= filled_q + 1'b1;
				end
			end

			if (start_sum) begin
				tap_q <= '0;
			end else if (issue) begin
				tap_q <= tap_q + 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// read addresses: tap 0 is the block after the current one, then one
	// block further per tap; coefficients step by one block from position k
	always_ff @(posedge clk) begin
		if (start_sum) begin
			hist_addr_q <= next_block(pos_q);
			coef_addr_q <= AW'(k_q);
			item_k_q    <= k_q;
		end else if (issue) begin
			hist_addr_q <= next_block(hist_addr_q);
			coef_addr_q <= coef_addr_q + AW'(BLOCK_LEN);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			bin_q        <= pfbfe_pkg::BIN_W'(item_k_q);
			out_real_q   <= mac_re;
			out_imag_q   <= mac_im;
			frame_last_q <= (item_k_q == KW'(BLOCK_LEN - 1));
		end
	end

	// ---------------------------------------------------------------- memories
	// swap on entry: filter real (recorder imag) in the high byte
	assign hist_we    = acc_data;
	assign hist_wdata = {rec_imag, rec_real};
	assign coef_we    = acc_coeff & coeff_in_range;
	assign coef_waddr = AW'(coeff_index);

	pfbfe_ram #(
		.WIDTH (pfbfe_pkg::HIST_W),
		.DEPTH (HIST_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (pos_q),
		.wdata (hist_wdata),
		.re    (issue),
		.raddr (hist_addr_q),
		.rdata (hist_rdata)
	);

	pfbfe_ram #(
		.WIDTH (pfbfe_pkg::COEF_W),
		.DEPTH (HIST_DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coeff_value),
		.re    (issue),
		.raddr (coef_addr_q),
		.rdata (coef_rdata)
	);

	// ---------------------------------------------------------------- MAC
	assign mac_ctrl.clear    = start_sum;
	assign mac_ctrl.valid_s1 = rd_valid_s1;
	assign mac_ctrl.last_s1  = rd_last_s1;

	pfbfe_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mac_ctrl),
		.hist_data (hist_rdata),
		.coef_data (coef_rdata),
		.done      (mac_done),
		.sum_re    (mac_re),
		.sum_im    (mac_im)
	);

	// ---------------------------------------------------------------- outputs
	assign out_valid  = out_valid_q;
	assign bin_index  = bin_q;
	assign out_real   = out_real_q;
	assign out_imag   = out_imag_q;
	assign frame_last = frame_last_q;

endmodule

@@ rtl/core/pfbfe_checker.sv @@
// ----------------------------------------------------------------------------
// pfbfe_checker
// Port-level checks for the filter bank front end, bound to the top level.
// ----------------------------------------------------------------------------
module pfbfe_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                func,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [pfbfe_pkg::BIN_W-1:0]         bin_index,
	input logic signed [pfbfe_pkg::SUM_W-1:0]  out_real
);

	// a stalled output transaction stays offered
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction dropped while stalled");

	// and its bin index and real part hold
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(bin_index) && $stable(out_real))
		else $error("output payload changed while stalled");

	// a coefficient write never produces a bin
	a_coeff_no_bin: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == pfbfe_pkg::FUNC_COEFF |=> !$rose(out_valid))
		else $error("bin produced by a coefficient write");

	// a new bin only appears after the block was busy computing it
	a_bin_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("bin appeared without a preceding computation");

endmodule

bind polyphase_filter_bank_front_end_unit pfbfe_checker u_pfbfe_checker (.*);
